@@ design/rctw_pkg.sv @@
// Shared types, constants and helpers for the ray-cast column texture walker.
// No dependencies; every other design file uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rctw_pkg;

   localparam int DIV_QW   = 32;
   localparam int DIV_DW   = 36;
   localparam int DIST6_W  = 35;
   localparam int LH_SCALE = 65536 * 5;
   localparam int SIZE_W   = 13;
   localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

   localparam logic [1:0] CSR_CEILING_COLOR = 2'd0;
   localparam logic [1:0] CSR_FLOOR_COLOR   = 2'd1;
   localparam logic [1:0] CSR_TEX_WIDTH     = 2'd2;
   localparam logic [1:0] CSR_TEX_HEIGHT    = 2'd3;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_ROW  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_CEILING = 2'd0,
      KIND_WALL    = 2'd1,
      KIND_FLOOR   = 2'd2,
      KIND_SKIPPED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LH,
      ST_STEP,
      ST_POS
   } state_type;

   typedef struct packed {
      logic        action;
      logic [11:0] column;
      logic        side;
      logic        dir_x_positive;
      logic        dir_y_negative;
      logic [31:0] perp_dist;
      logic [15:0] wall_frac;
   } req_type;

   typedef struct packed {
      logic [11:0] out_column;
      logic [8:0]  out_row;
      logic [1:0]  pixel_kind;
      logic [1:0]  tex_select;
      logic [23:0] texel_index;
      logic [31:0] fill_color;
      logic        last_row;
   } rsp_type;

   typedef struct packed {
      op_type               op;
      logic [11:0]          column;
      logic [1:0]           face;
      logic [DIST6_W-1:0]   dist6;
      logic [15:0]          frac;
   } item_type;

   typedef struct packed {
      logic [31:0]       ceiling_color;
      logic [31:0]       floor_color;
      logic [SIZE_W-1:0] tex_w;
      logic [SIZE_W-1:0] tex_h;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIV_QW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_QW-1:0] quotient;
   } div_rsp_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) r = 13'd1;
      else if (v > SIZE_MAX) r = SIZE_MAX;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/rctw_front.sv @@
// Front end: takes request transfers, classifies them and queues them for the back end.
// Depends on rctw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rctw_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire rctw_pkg::req_type  req_data,
   output logic                    item_valid,
   output rctw_pkg::item_type      item,
   input  wire logic               item_pop
);

   localparam logic [1:0] DEPTH = 2'd2;

   rctw_pkg::item_type slot_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;
   logic [31:0] dist_eff;
   logic [rctw_pkg::DIST6_W-1:0] dist_ext;
   rctw_pkg::item_type cls;

   always_comb begin
      dist_eff  = (req_data.perp_dist == '0) ? 32'd1 : req_data.perp_dist;
      dist_ext  = rctw_pkg::DIST6_W'(dist_eff);
      cls.op    = req_data.action ? rctw_pkg::OP_ROW : rctw_pkg::OP_LOAD;
      cls.column = req_data.column;
      cls.face  = {req_data.side,
                   req_data.side ? req_data.dir_y_negative : req_data.dir_x_positive};
      cls.dist6 = (dist_ext << 2) + (dist_ext << 1);
      cls.frac  = req_data.wall_frac;
   end

   assign req_full   = (cnt_ff == DEPTH);
   assign item_valid = (cnt_ff != '0);
   assign item       = slot_ff[rp_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_pop && item_valid;

   always_comb begin
      wp_in  = push_ok ? ~wp_ff : wp_ff;
      rp_in  = pop_ok ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wp_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

@@ design/rctw_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on rctw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rctw_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rctw_pkg::div_req_type req,
   output rctw_pkg::div_rsp_type      rsp
);

   localparam int QW = rctw_pkg::DIV_QW;
   localparam int DW = rctw_pkg::DIV_DW;
   localparam int CW = $clog2(QW);

   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial, diff;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[QW-1]};
      ge      = (trial >= {1'b0, den_ff});
      diff    = trial - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

@@ design/rctw_back.sv @@
// Back end: ray setup sequencer, per-row pixel generation and the result queue.
// Depends on rctw_pkg; drives the shared divider rctw_div.
`timescale 1ns / 1ps
`default_nettype none

module rctw_back #(
   parameter int SCREEN_HEIGHT = 512
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rctw_pkg::cfg_type     cfg,
   input  wire logic                  item_valid,
   input  wire rctw_pkg::item_type    item,
   output logic                       item_pop,
   output rctw_pkg::div_req_type      div_req,
   input  wire rctw_pkg::div_rsp_type div_rsp,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output rctw_pkg::rsp_type          rsp_data
);

   localparam int RW   = $clog2(SCREEN_HEIGHT + 1);
   localparam int HALF = SCREEN_HEIGHT / 2;
   localparam logic [RW-1:0] ROWS   = RW'(SCREEN_HEIGHT);
   localparam logic [RW-1:0] LAST   = RW'(SCREEN_HEIGHT - 1);
   localparam logic [RW-1:0] HALF_R = RW'(HALF);
   localparam logic [31:0]   HALF_W = 32'(HALF);
   localparam logic [31:0]   LH_NUM = 32'(SCREEN_HEIGHT * rctw_pkg::LH_SCALE);
   localparam logic [1:0]    OQ_DEPTH = 2'd2;

   rctw_pkg::state_type state_ff, state_in;
   logic [11:0]   col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] first_ff, first_in;
   logic [RW-1:0] left_ff, left_in;
   logic [31:0]   pos_ff, pos_in;
   logic [31:0]   step_ff, step_in;
   logic [31:0]   offset_ff, offset_in;
   logic [11:0]   tcol_ff, tcol_in;
   logic [1:0]    face_ff, face_in;
   logic [15:0]   frac_ff, frac_in;

   rctw_pkg::rsp_type oq_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       oq_full, push, pop_ok;
   rctw_pkg::rsp_type pix;
   rctw_pkg::kind_type kind;

   logic [15:0]   trow;
   logic [28:0]   texel_prod;
   logic [31:0]   lh, lh_half;
   logic [RW-1:0] first_c, avail_c;
   logic [28:0]   tc_prod;
   logic [12:0]   tc0, tc;

   assign oq_full   = (cnt_ff == OQ_DEPTH);
   assign rsp_empty = (cnt_ff == '0);
   assign rsp_data  = oq_ff[rp_ff];
   assign pop_ok    = rsp_pop && !rsp_empty;

   always_comb begin
      trow       = pos_ff[31:16];
      texel_prod = trow * cfg.tex_w;
      lh         = div_rsp.quotient;
      lh_half    = lh >> 1;
      first_c    = (lh_half < HALF_W) ? (HALF_R - lh_half[RW-1:0]) : '0;
      avail_c    = ROWS - first_c;
      tc_prod    = frac_ff * cfg.tex_w;
      tc0        = tc_prod[28:16];
      tc         = face_ff[0] ? (cfg.tex_w - 13'd1 - tc0) : tc0;

      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      first_in  = first_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      step_in   = step_ff;
      offset_in = offset_ff;
      tcol_in   = tcol_ff;
      face_in   = face_ff;
      frac_in   = frac_ff;
      item_pop  = 1'b0;
      div_req   = '0;
      push      = 1'b0;
      kind      = rctw_pkg::KIND_FLOOR;

      pix.out_column  = col_ff;
      pix.out_row     = 9'(row_ff);
      pix.tex_select  = face_ff;
      pix.texel_index = '0;
      pix.fill_color  = '0;
      pix.last_row    = (row_ff == LAST);
      if (row_ff < first_ff) begin
         kind           = rctw_pkg::KIND_CEILING;
         pix.fill_color = cfg.ceiling_color;
      end else if (left_ff != '0) begin
         kind = (trow < 16'(cfg.tex_h)) ? rctw_pkg::KIND_WALL : rctw_pkg::KIND_SKIPPED;
         pix.texel_index = 24'(texel_prod + 29'(tcol_ff));
      end else begin
         pix.fill_color = cfg.floor_color;
      end
      pix.pixel_kind = kind;

      case (state_ff)
         rctw_pkg::ST_IDLE: begin
            if (item_valid) begin
               if (item.op == rctw_pkg::OP_LOAD) begin
                  item_pop         = 1'b1;
                  col_in           = item.column;
                  face_in          = item.face;
                  frac_in          = item.frac;
                  row_in           = '0;
                  div_req.start    = 1'b1;
                  div_req.dividend = LH_NUM;
                  div_req.divisor  = rctw_pkg::DIV_DW'(item.dist6);
                  state_in         = rctw_pkg::ST_LH;
               end else if (row_ff >= ROWS) begin
                  item_pop = 1'b1;
               end else if (!oq_full) begin
                  item_pop = 1'b1;
                  push     = 1'b1;
                  row_in   = row_ff + RW'(1);
                  if (row_ff >= first_ff && left_ff != '0) begin
                     left_in = left_ff - RW'(1);
                     pos_in  = pos_ff + step_ff;
                  end
               end
            end
         end
         rctw_pkg::ST_LH: begin
            if (div_rsp.done) begin
               first_in  = first_c;
               left_in   = (lh < 32'(avail_c)) ? lh[RW-1:0] : avail_c;
               offset_in = (lh_half < HALF_W) ? 32'd0 : (lh_half - HALF_W);
               tcol_in   = tc[11:0];
               if (lh == '0) begin
                  step_in  = '0;
                  pos_in   = '0;
                  state_in = rctw_pkg::ST_IDLE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {3'b0, cfg.tex_h, 16'b0};
                  div_req.divisor  = rctw_pkg::DIV_DW'(lh);
                  state_in         = rctw_pkg::ST_STEP;
               end
            end
         end
         rctw_pkg::ST_STEP: begin
            if (div_rsp.done) begin
               step_in  = div_rsp.quotient;
               state_in = rctw_pkg::ST_POS;
            end
         end
         rctw_pkg::ST_POS: begin
            pos_in   = 32'(offset_ff * step_ff);
            state_in = rctw_pkg::ST_IDLE;
         end
         default: begin
            state_in = rctw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rctw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         first_ff <= '0;
         left_ff  <= '0;
         pos_ff   <= '0;
         step_ff  <= '0;
         tcol_ff  <= '0;
         face_ff  <= '0;
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         first_ff <= first_in;
         left_ff  <= left_in;
         pos_ff   <= pos_in;
         step_ff  <= step_in;
         tcol_ff  <= tcol_in;
         face_ff  <= face_in;
         wp_ff    <= push ? ~wp_ff : wp_ff;
         rp_ff    <= pop_ok ? ~rp_ff : rp_ff;
         cnt_ff   <= cnt_ff + 2'(push) - 2'(pop_ok);
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      frac_ff   <= frac_in;
      if (push) begin
         oq_ff[wp_ff] <= pix;
      end
   end

`ifndef SYNTHESIS
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= OQ_DEPTH)
      else $error("result queue overflow");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rctw_pkg::ST_IDLE) |-> !item_pop)
      else $error("item taken during ray setup");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      push |-> (row_ff < ROWS))
      else $error("pixel emitted past the last row");
   a_step_to_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rctw_pkg::ST_STEP && div_rsp.done) |=> (state_ff == rctw_pkg::ST_POS))
      else $error("setup sequence skipped position update");
`endif

endmodule

`default_nettype wire

@@ design/raycast_column_texture_walker.sv @@
// Ray-cast textured wall column walker: a row request gives at most one pixel transfer.
// Rows pass the front and result queues; one row per cycle while the result queue has room.
// A load holds the back end for two 32-step serial divides, one for zero wall height.
// The shared divider sets the load time; rows are blocked while a load is set up.
// Synchronous active-high reset clears queues and column state; textures revert to 64x64.
// Depends on rctw_pkg, rctw_front, rctw_div and rctw_back.
`timescale 1ns / 1ps
`default_nettype none

module raycast_column_texture_walker #(
   parameter int SCREEN_HEIGHT = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire rctw_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output rctw_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);

   logic [31:0] ceiling_ff, floor_ff;
   logic [rctw_pkg::SIZE_W-1:0] tex_w_ff, tex_h_ff;
   rctw_pkg::cfg_type     cfg;
   rctw_pkg::item_type    item;
   logic                  item_valid, item_pop;
   rctw_pkg::div_req_type div_req;
   rctw_pkg::div_rsp_type div_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= '0;
         floor_ff   <= '0;
         tex_w_ff   <= 13'd64;
         tex_h_ff   <= 13'd64;
      end else if (csr_write) begin
         case (csr_index)
            rctw_pkg::CSR_CEILING_COLOR: ceiling_ff <= csr_wdata;
            rctw_pkg::CSR_FLOOR_COLOR:   floor_ff   <= csr_wdata;
            rctw_pkg::CSR_TEX_WIDTH:     tex_w_ff   <= csr_wdata[12:0];
            rctw_pkg::CSR_TEX_HEIGHT:    tex_h_ff   <= csr_wdata[12:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.ceiling_color = ceiling_ff;
      cfg.floor_color   = floor_ff;
      cfg.tex_w         = rctw_pkg::eff_size(tex_w_ff);
      cfg.tex_h         = rctw_pkg::eff_size(tex_h_ff);
   end

   rctw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   rctw_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rctw_back #(
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for raycast_column_texture_walker: a directed table, then random ray loads and
// row requests under random idling on both queues, each pixel checked by table or predictor.
// Depends on rctw_pkg and the walker RTL only.
`timescale 1ns / 1ps

module testbench;

   localparam int SCREEN_H    = 512;
   localparam int HALF_H      = SCREEN_H / 2;
   localparam int LOAD_CYCLES = 300;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 153;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_REPORTS = 60;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   rctw_pkg::req_type req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   rctw_pkg::rsp_type rsp_data;
   logic              csr_write = 1'b0;
   logic [1:0]        csr_index = rctw_pkg::CSR_CEILING_COLOR;
   logic [31:0]       csr_wdata = '0;

   raycast_column_texture_walker #(.SCREEN_HEIGHT(SCREEN_H)) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      rctw_pkg::req_type req;
      bit                typed;
      rctw_pkg::rsp_type want;
   } plan_row_type;

   plan_row_type      plan[$];
   rctw_pkg::rsp_type pixels_due[$];

   // predictor: registers and column state
   logic [31:0] ceil_rgba, floor_rgba;
   logic [12:0] tex_w_reg, tex_h_reg;
   logic [11:0] ray_column, ray_tex_col;
   int unsigned ray_row, ray_first;
   logic [31:0] ray_wall_left, ray_tex_pos, ray_tex_step;
   logic [1:0]  ray_face;

   int errors = 0, reports = 0, loads_seen = 0, rows_sent = 0;
   int pixels_checked = 0, settings_used = 0;
   int kind_count[4] = '{default: 0};
   bit calm = 1'b0, tx_gappy = 1'b1, rx_gappy = 1'b1;
   bit hold_rsp = 1'b0, pressure = 1'b0, pressure_done = 1'b0;
   int rows_pending = 0;
   bit len_open = 1'b0;
   int len_mode = 0;

   function automatic logic [63:0] size_clamp(input logic [12:0] v);
      if (v == '0) return 64'd1;
      if (v > 13'd4096) return 64'd4096;
      return {51'd0, v};
   endfunction

   function automatic void power_on_state();
      ceil_rgba     = '0;
      floor_rgba    = '0;
      tex_w_reg     = 13'd64;
      tex_h_reg     = 13'd64;
      ray_column    = '0;
      ray_row       = 0;
      ray_first     = 0;
      ray_wall_left = '0;
      ray_tex_pos   = '0;
      ray_tex_step  = '0;
      ray_tex_col   = '0;
      ray_face      = '0;
   endfunction

   function automatic void latch_ray(input rctw_pkg::req_type r);
      logic [63:0] span, lh, lh_half, first, avail, stepv, prod, tc, w, h;
      span = {32'd0, r.perp_dist};
      if (span == 0) span = 64'd1;
      w = size_clamp(tex_w_reg);
      h = size_clamp(tex_h_reg);
      lh = (64'd5 * 64'd65536 * SCREEN_H) / (span * 64'd6);
      lh_half = lh >> 1;
      first = (lh_half < HALF_H) ? HALF_H - lh_half : 64'd0;
      avail = SCREEN_H - first;
      ray_column = r.column;
      ray_row = 0;
      ray_first = first[31:0];
      ray_wall_left = (lh < avail) ? lh[31:0] : avail[31:0];
      if (lh == 0) begin
         ray_tex_step = '0;
         ray_tex_pos = '0;
      end else begin
         stepv = (h << 16) / lh;
         prod = (first + lh_half - HALF_H) * stepv;
         ray_tex_step = stepv[31:0];
         ray_tex_pos = prod[31:0];
      end
      ray_face = {r.side, r.side ? r.dir_y_negative : r.dir_x_positive};
      tc = ({48'd0, r.wall_frac} * w) >> 16;
      if (ray_face[0]) tc = w - 64'd1 - tc;
      ray_tex_col = tc[11:0];
   endfunction

   function automatic bit next_pixel(output rctw_pkg::rsp_type px);
      logic [63:0] trow, prod;
      px = '0;
      if (ray_row >= SCREEN_H) return 1'b0;
      px.out_column = ray_column;
      px.out_row = ray_row[8:0];
      px.tex_select = ray_face;
      px.last_row = (ray_row == SCREEN_H - 1);
      if (ray_row < ray_first) begin
         px.pixel_kind = rctw_pkg::KIND_CEILING;
         px.fill_color = ceil_rgba;
      end else if (ray_wall_left != 0) begin
         trow = {32'd0, ray_tex_pos} >> 16;
         px.pixel_kind = (trow < size_clamp(tex_h_reg)) ? rctw_pkg::KIND_WALL
                                                        : rctw_pkg::KIND_SKIPPED;
         prod = trow * size_clamp(tex_w_reg) + {52'd0, ray_tex_col};
         px.texel_index = prod[23:0];
         ray_wall_left = ray_wall_left - 32'd1;
         ray_tex_pos = ray_tex_pos + ray_tex_step;
      end else begin
         px.pixel_kind = rctw_pkg::KIND_FLOOR;
         px.fill_color = floor_rgba;
      end
      ray_row++;
      return 1'b1;
   endfunction

   // applies one accepted request; returns 0 for a row request past the bottom of the column
   function automatic bit book(input rctw_pkg::req_type r, input bit typed,
                               input rctw_pkg::rsp_type want);
      rctw_pkg::rsp_type px;
      if (r.action == rctw_pkg::OP_LOAD) begin
         latch_ray(r);
         loads_seen++;
         return 1'b1;
      end
      rows_sent++;
      if (!next_pixel(px)) return 1'b0;
      pixels_due.push_back(typed ? want : px);
      return 1'b1;
   endfunction

   function automatic void plan_load(input logic [11:0] col, input bit side, input bit dxp,
                                     input bit dyn, input logic [31:0] span,
                                     input logic [15:0] frac);
      plan_row_type p;
      p.req = '0;
      p.req.action = rctw_pkg::OP_LOAD;
      p.req.column = col;
      p.req.side = side;
      p.req.dir_x_positive = dxp;
      p.req.dir_y_negative = dyn;
      p.req.perp_dist = span;
      p.req.wall_frac = frac;
      p.typed = 1'b0;
      p.want = '0;
      plan.push_back(p);
   endfunction

   function automatic void plan_row(input bit junk, input bit typed,
                                    input rctw_pkg::rsp_type want);
      plan_row_type p;
      p.req = junk ? '1 : '0;
      p.req.action = rctw_pkg::OP_ROW;
      p.typed = typed;
      p.want = want;
      plan.push_back(p);
   endfunction

   function automatic rctw_pkg::rsp_type pixel(input logic [11:0] col, input logic [8:0] row,
                                               input rctw_pkg::kind_type kind,
                                               input logic [1:0] sel);
      rctw_pkg::rsp_type px;
      px = '0;
      px.out_column = col;
      px.out_row = row;
      px.pixel_kind = kind;
      px.tex_select = sel;
      return px;
   endfunction

   task automatic field_check(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         errors++;
         if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         end
      end
   endtask

   task automatic take_pixel(input rctw_pkg::rsp_type got);
      rctw_pkg::rsp_type want;
      if (pixels_due.size() == 0) begin
         errors++;
         if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: pixel transfer mismatch, expected none, got %h", $time, got);
         end
         return;
      end
      want = pixels_due.pop_front();
      field_check("out_column", want.out_column, got.out_column);
      field_check("out_row", want.out_row, got.out_row);
      field_check("pixel_kind", want.pixel_kind, got.pixel_kind);
      field_check("tex_select", want.tex_select, got.tex_select);
      field_check("texel_index", want.texel_index, got.texel_index);
      field_check("fill_color", want.fill_color, got.fill_color);
      field_check("last_row", want.last_row, got.last_row);
      pixels_checked++;
      kind_count[want.pixel_kind]++;
   endtask

   // waits for a falling edge, returns at the rising edge of the transfer
   task automatic offer(input rctw_pkg::req_type r);
      @(negedge clock);
      if (tx_gappy && !calm && !pressure && $urandom_range(0, 3) == 0) begin
         req_push = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_data = r;
      req_push = 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if ($urandom_range(0, 59) == 0) tx_gappy = !tx_gappy;
   endtask

   task automatic drain_and_pause();
      @(negedge clock);
      req_push = 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (LOAD_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_put(input logic [1:0] idx, input logic [31:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         rctw_pkg::CSR_CEILING_COLOR: ceil_rgba = val;
         rctw_pkg::CSR_FLOOR_COLOR:   floor_rgba = val;
         rctw_pkg::CSR_TEX_WIDTH:     tex_w_reg = val[12:0];
         rctw_pkg::CSR_TEX_HEIGHT:    tex_h_reg = val[12:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_setting(input int ph);
      logic [31:0] c, f, tw, th;
      c = $urandom;
      f = $urandom;
      tw = 32'd64;
      th = 32'd64;
      case (ph)
         1: begin
            c = '1;
            f = '0;
            tw = 32'd1;
            th = 32'd1;
         end
         2: begin
            c = '0;
            f = '1;
            tw = 32'd4096;
            th = 32'd4096;
         end
         3: begin
            tw = 32'd0;
            th = 32'd0;
         end
         4: begin
            tw = '1;
            th = 32'h0000_1001;
         end
         5: begin
            tw = $urandom_range(1, 4096);
            th = $urandom_range(1, 4096);
         end
         6: begin
            tw = 32'd4096;
            th = 32'd4096;
         end
         7: begin
            tw = $urandom;
            th = $urandom_range(1, 8);
         end
         8: begin
            tw = $urandom_range(1, 200);
            th = $urandom_range(1, 200);
         end
         default: ;
      endcase
      drain_and_pause();
      csr_put(rctw_pkg::CSR_CEILING_COLOR, c);
      csr_put(rctw_pkg::CSR_FLOOR_COLOR, f);
      csr_put(rctw_pkg::CSR_TEX_WIDTH, tw);
      csr_put(rctw_pkg::CSR_TEX_HEIGHT, th);
      csr_write = 1'b0;
      settings_used++;
   endtask

   // a load followed by a run of rows, maybe none; the run length is fixed once the ray is known
   task automatic make_ray_item(output rctw_pkg::req_type r);
      r = {$urandom, $urandom};
      if (rows_pending == 0 && !len_open) begin
         r.action = rctw_pkg::OP_LOAD;
         case ($urandom_range(0, 9))
            0:       r.perp_dist = $urandom_range(0, 32'h0000_D555);
            1, 2:    r.perp_dist = $urandom_range(32'h0000_D556, 32'h0004_0000);
            3:       r.perp_dist = $urandom_range(32'h0004_0000, 32'h0100_0000);
            4:       ;
            5: begin
               case ($urandom_range(0, 2))
                  0:       r.perp_dist = 32'd0;
                  1:       r.perp_dist = 32'd1;
                  default: r.perp_dist = '1;
               endcase
            end
            default: r.perp_dist = $urandom_range(32'h0000_8000, 32'h0003_0000);
         endcase
         len_mode = pressure_done ? $urandom_range(0, 9) : 1;
         len_open = (len_mode != 0);
         if (len_mode == 1 && !pressure_done) begin
            pressure_done = 1'b1;
            pressure = 1'b1;
            hold_rsp = 1'b1;
         end
      end else begin
         r.action = rctw_pkg::OP_ROW;
         if (len_open) begin
            rows_pending = (len_mode == 1) ? SCREEN_H + $urandom_range(0, 6)
                                           : int'(ray_first) + $urandom_range(1, 24);
            len_open = 1'b0;
         end
         rows_pending--;
         if (rows_pending == 0) pressure = 1'b0;
      end
   endtask

   initial begin
      int phase_items;
      rctw_pkg::req_type r;
      power_on_state();
      plan_row(1'b0, 1'b1, pixel(12'd0, 9'd0, rctw_pkg::KIND_FLOOR, 2'b00));
      plan_row(1'b1, 1'b1, pixel(12'd0, 9'd1, rctw_pkg::KIND_FLOOR, 2'b00));
      plan_load(12'd4095, 1'b0, 1'b1, 1'b0, 32'd0, 16'hFFFF);
      plan_row(1'b0, 1'b1, pixel(12'd4095, 9'd0, rctw_pkg::KIND_WALL, 2'b01));
      plan_row(1'b1, 1'b1, pixel(12'd4095, 9'd1, rctw_pkg::KIND_WALL, 2'b01));
      plan_load(12'd0, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'h0000);
      plan_row(1'b0, 1'b1, pixel(12'd0, 9'd0, rctw_pkg::KIND_CEILING, 2'b11));
      plan_load(12'd2048, 1'b1, 1'b1, 1'b0, 32'h0001_0000, 16'h8000);
      plan_row(1'b0, 1'b0, '0);
      plan_row(1'b1, 1'b0, '0);
      plan_load(12'd1, 1'b0, 1'b0, 1'b1, 32'd1, 16'h0001);
      plan_row(1'b0, 1'b1, pixel(12'd1, 9'd0, rctw_pkg::KIND_WALL, 2'b00));
      plan_row(1'b1, 1'b1, pixel(12'd1, 9'd1, rctw_pkg::KIND_WALL, 2'b00));
      // line height just at and just under the screen height
      plan_load(12'd100, 1'b0, 1'b1, 1'b1, 32'h0000_D555, 16'h4000);
      plan_row(1'b0, 1'b0, '0);
      plan_row(1'b0, 1'b0, '0);
      plan_load(12'd7, 1'b1, 1'b0, 1'b0, 32'h0000_D556, 16'hFFFF);
      plan_row(1'b0, 1'b0, '0);
      plan_row(1'b1, 1'b0, '0);
      plan_load(12'd4095, 1'b1, 1'b1, 1'b1, 32'h0028_0000, 16'h0000);
      plan_row(1'b0, 1'b0, '0);
      plan_row(1'b0, 1'b0, '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         offer(plan[i].req);
         void'(book(plan[i].req, plan[i].typed, plan[i].want));
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         apply_setting(ph);
         calm = (ph == PHASES - 1);
         phase_items = 0;
         // phases end inside a wall run where possible, so texture changes land mid-column
         while (phase_items < PHASE_ITEMS ||
                (phase_items < PHASE_ITEMS + 600 &&
                 !(ray_row >= ray_first && ray_wall_left > 4))) begin
            make_ray_item(r);
            offer(r);
            if (book(r, 1'b0, '0)) phase_items++;
         end
      end

      @(negedge clock);
      req_push = 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (LOAD_CYCLES) @(posedge clock);
      $display("Ran %0d loads, %0d row requests, %0d register settings; %0d pixels checked.",
               loads_seen, rows_sent, settings_used + 1, pixels_checked);
      $display("Pixel mix: ceiling %0d, wall %0d, floor %0d, skipped %0d; %0d mismatches.",
               kind_count[rctw_pkg::KIND_CEILING], kind_count[rctw_pkg::KIND_WALL],
               kind_count[rctw_pkg::KIND_FLOOR], kind_count[rctw_pkg::KIND_SKIPPED], errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rx_gappy && !calm && $urandom_range(0, 5) == 0) begin
            rsp_pop = 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_pop = 1'b1;
            @(posedge clock);
            if (!rsp_empty) begin
               take_pixel(rsp_data);
               if ($urandom_range(0, 49) == 0) rx_gappy = !rx_gappy;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("%0t: run did not complete in time", $time);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
